### rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pic3_pkg.sv
package pic3_pkg;

  localparam int unsigned Channels = 3;
  localparam int unsigned DutyMax  = 255;
  localparam int unsigned NumTuned = 3;
  localparam int unsigned ApbAddrW = 4;

  localparam logic [7:0] StepSizeReset = 8'd1;

  localparam logic [1:0] RegStepSize = 2'd0;
  localparam logic [1:0] RegCh1      = 2'd1;
  localparam logic [1:0] RegCh2      = 2'd2;
  localparam logic [1:0] RegCh3      = 2'd3;

  typedef struct packed {
    logic [1:0]          channel;
    logic signed [15:0]  temperature;
  } pic3_in_t;

  typedef struct packed {
    logic [1:0] channel_out;
    logic [7:0] duty;
  } pic3_out_t;

endpackage

### rtl/pi_controller_three_channel_unit.sv
// Three-channel PI controller with anti-windup.
// Input channel: in_valid_i/in_ready_o with in_data_i (channel, temperature).
// Output channel: out_valid_o/out_ready_i with out_data_o (channel_out, duty).
// A transfer on channel 0, or above the configured channel count, is taken and
// dropped without a result or a change of state.
// Tuning registers sit on the APB port: 0 step size, 1..3 per-channel tuning.
// Write them only while the block is idle.
// One item is worked at a time, through the read, accumulate, second multiply,
// windup check, third multiply, fourth multiply and final sum steps. When the
// windup limit fires, the bit-serial divider computing the limit quotient runs
// between the windup check and the third multiply. A shared 32x9 multiplier is
// used four times per item. The next item is taken the cycle after the result
// is loaded into the output register.
// Reset clears the tuning registers (step size to 1) and marks all integrators
// as zero through per-entry valid bits; no clearing pass is needed.
// If the receiver stalls, the result waits in the output register while the
// next item is taken and worked; that item holds in its final step until the
// output register frees up.
module pi_controller_three_channel_unit
  import pic3_pkg::*;
#(
  parameter int unsigned CHANNELS = Channels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pic3_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pic3_out_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ACC, S_M2, S_WIND, S_DIV, S_M3, S_M4, S_SUM
  } state_e;

  state_e state_q;

  // configuration
  logic [7:0]  step_q;
  logic [31:0] tuning_q [NumTuned];
  logic [1:0]  reg_sel;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepSizeReset;
      for (int i = 0; i < NumTuned; i++) tuning_q[i] <= '0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        RegStepSize: step_q      <= pwdata[7:0];
        RegCh1:      tuning_q[0] <= pwdata;
        RegCh2:      tuning_q[1] <= pwdata;
        RegCh3:      tuning_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegStepSize: prdata = {24'd0, step_q};
      RegCh1:      prdata = tuning_q[0];
      RegCh2:      prdata = tuning_q[1];
      RegCh3:      prdata = tuning_q[2];
      default:     prdata = '0;
    endcase
  end

  // input decode
  logic [1:0]  in_ch_m1;
  logic        in_ch_ok;
  logic [31:0] in_tun;
  logic signed [16:0] in_err;
  logic        in_acc;
  logic        mem_re;

  assign in_ch_m1 = in_data_i.channel - 2'd1;
  assign in_ch_ok = (in_data_i.channel != 2'd0)
                 && (32'(in_data_i.channel) <= CHANNELS)
                 && (32'(in_data_i.channel) <= NumTuned);
  assign in_tun   = (32'(in_ch_m1) < NumTuned) ? tuning_q[in_ch_m1] : '0;
  assign in_err   = 17'(in_data_i.temperature) - 17'($signed(in_tun[15:0]));
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign mem_re   = in_acc && in_ch_ok;

  // per-item registers
  logic [1:0]         ch_q;
  logic [IdxW-1:0]    idx_q;
  logic signed [16:0] err_q;
  logic signed [31:0] integ_q;
  logic signed [40:0] prod_q;
  logic signed [40:0] acc_q;
  logic [7:0]         kp, ki;

  assign kp = tuning_q[ch_q - 2'd1][23:16];
  assign ki = tuning_q[ch_q - 2'd1][31:24];

  // integrator memory with reset-cleared valid bits
  logic [31:0]     integ_mem [CHANNELS];
  logic [31:0]     rdata_q;
  logic            rd_vld_q;
  logic [CHANNELS-1:0] vld_q;
  logic [IdxW-1:0] rd_idx;
  logic            mem_we;
  logic [31:0]     wdata;

  assign rd_idx = IdxW'(in_ch_m1);

  always_ff @(posedge clk_i) begin
    if (mem_we) integ_mem[idx_q] <= wdata;
    if (mem_re) rdata_q <= integ_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[idx_q] <= 1'b1;
      if (mem_re) rd_vld_q <= vld_q[rd_idx];
    end
  end

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [8:0]  mul_b;
  logic signed [40:0] prod_d;

  always_comb begin
    case (state_q)
      S_READ: begin
        mul_a = 32'(err_q);
        mul_b = $signed({1'b0, step_q});
      end
      S_M2, S_M3: begin
        mul_a = integ_q;
        mul_b = $signed({1'b0, ki});
      end
      default: begin
        mul_a = 32'(err_q);
        mul_b = $signed({1'b0, kp});
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // saturating accumulate
  logic signed [32:0] acc_sum;
  logic signed [31:0] stored;
  logic signed [31:0] integ_sat;

  assign stored  = rd_vld_q ? $signed(rdata_q) : 32'sd0;
  assign acc_sum = 33'(stored) + 33'($signed(prod_q[25:0]));

  always_comb begin
    if (acc_sum[32] != acc_sum[31]) begin
      integ_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      integ_sat = acc_sum[31:0];
    end
  end

  logic wind_fire;
  assign wind_fire = (prod_q > $signed(41'(DutyMax))) && (ki != 8'd0);

  // bit-serial divider for DutyMax / ki
  logic [7:0] div_rem_q, div_quo_q;
  logic [2:0] div_cnt_q;
  logic [8:0] div_sh;
  logic       div_bit;
  logic [7:0] div_rem_d, div_quo_d;

  assign div_sh    = {div_rem_q, div_quo_q[7]};
  assign div_bit   = (div_sh >= {1'b0, ki});
  assign div_rem_d = div_bit ? 8'(div_sh - {1'b0, ki}) : div_sh[7:0];
  assign div_quo_d = {div_quo_q[6:0], div_bit};

  // final sum and clamp
  logic signed [41:0] duty_sum;
  logic               duty_neg;
  logic [7:0]         duty_d;
  logic               out_free;

  assign duty_sum = 42'(acc_q) + 42'(prod_q);
  assign duty_neg = duty_sum[41];
  assign out_free = !out_valid_o || out_ready_i;
  assign mem_we   = (state_q == S_SUM) && out_free;
  assign wdata    = duty_neg ? '0 : integ_q;

  always_comb begin
    if (duty_neg) begin
      duty_d = '0;
    end else if (duty_sum > 42'(DutyMax)) begin
      duty_d = 8'(DutyMax);
    end else begin
      duty_d = duty_sum[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (mem_re) begin
      ch_q  <= in_data_i.channel;
      idx_q <= rd_idx;
      err_q <= in_err;
    end
    if (state_q == S_ACC) integ_q <= integ_sat;
    if (state_q == S_WIND) begin
      div_rem_q <= '0;
      div_quo_q <= 8'(DutyMax);
    end
    if (state_q == S_DIV) begin
      div_rem_q <= div_rem_d;
      div_quo_q <= div_quo_d;
      if (div_cnt_q == 3'd7) integ_q <= 32'(div_quo_d);
    end
    if (state_q == S_M4) acc_q <= prod_q;
  end

  // control and output register
  logic      out_valid_q;
  pic3_out_t out_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_ready_i && (state_q != S_SUM)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (mem_re) state_q <= S_READ;
        S_READ: state_q <= S_ACC;
        S_ACC:  state_q <= S_M2;
        S_M2:   state_q <= S_WIND;
        S_WIND: begin
          div_cnt_q <= '0;
          state_q   <= wind_fire ? S_DIV : S_M3;
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + 3'd1;
          if (div_cnt_q == 3'd7) state_q <= S_M3;
        end
        S_M3:   state_q <= S_M4;
        S_M4:   state_q <= S_SUM;
        S_SUM: if (out_free) begin
          out_valid_q       <= 1'b1;
          out_q.channel_out <= ch_q;
          out_q.duty        <= duty_d;
          state_q           <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_take, mem_re, !in_ready_o, "valid item did not start work")
  `ASSERT_CLK(a_out_from_sum, $rose(out_valid_o) |-> $past(state_q) == S_SUM, "stray result")
  `ASSERT_NEXT(a_valid_after_write, mem_we, vld_q[idx_q], "integrator entry not marked valid")
  `ASSERT_CLK(a_div_rem_bound, state_q == S_DIV |-> div_rem_q < ki, "remainder out of range")

endmodule
